>>> src/ppmd_pkg.sv
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared types, constants and the microcode program of the PID position
// motor drive.
// ----------------------------------------------------------------------------
package ppmd_pkg;

  // Field widths.
  localparam int COUNT_W  = 16;
  localparam int TIME_W   = 32;
  localparam int TGT_W    = 9;
  localparam int COEF_W   = 16;
  localparam int ERR_W    = 21;
  localparam int SUM_W    = 32;
  localparam int PWM_W    = 8;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int CFG_IDX_W = 3;

  // Shared multiplier operands and product.
  localparam int MUL_A_W  = TIME_W + 1;
  localparam int MUL_B_W  = DIFF_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = PROD_W + 1;

  // Divider iteration count, one quotient bit per cycle plus a sign fix.
  localparam int DIV_STEPS = DIFF_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 2);

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [PWM_W-1:0]        PWM_MAX = 8'd255;
  localparam logic [COEF_W-1:0]       CTD_RESET = 16'd256;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_CTD    = 3'd1,
    REG_GAIN_P = 3'd2,
    REG_GAIN_I = 3'd3,
    REG_GAIN_D = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_POS,
    OP_ERR,
    OP_MUL_EDT,
    OP_SUM,
    OP_MUL_I,
    OP_MUL_P,
    OP_ACC_ADD,
    OP_MUL_D,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_WAIT_INPUT,
    COND_DIV_BUSY,
    COND_OUT_BUSY,
    COND_ALWAYS
  } cond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } dp_status_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_DIV_WAIT = 4'd8;
  localparam step_t STEP_OUT      = 4'd11;

  // The program: a jump is taken when the condition holds, otherwise the
  // step counter advances by one.
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
    case (s)
      4'd0:  w = '{op: OP_NOP,     cond: COND_WAIT_INPUT, target: STEP_IDLE};
      4'd1:  w = '{op: OP_MUL_POS, cond: COND_NEVER,      target: STEP_IDLE};
      4'd2:  w = '{op: OP_ERR,     cond: COND_NEVER,      target: STEP_IDLE};
      4'd3:  w = '{op: OP_MUL_EDT, cond: COND_NEVER,      target: STEP_IDLE};
      4'd4:  w = '{op: OP_SUM,     cond: COND_NEVER,      target: STEP_IDLE};
      4'd5:  w = '{op: OP_MUL_I,   cond: COND_NEVER,      target: STEP_IDLE};
      4'd6:  w = '{op: OP_MUL_P,   cond: COND_NEVER,      target: STEP_IDLE};
      4'd7:  w = '{op: OP_ACC_ADD, cond: COND_NEVER,      target: STEP_IDLE};
      4'd8:  w = '{op: OP_NOP,     cond: COND_DIV_BUSY,   target: STEP_DIV_WAIT};
      4'd9:  w = '{op: OP_MUL_D,   cond: COND_NEVER,      target: STEP_IDLE};
      4'd10: w = '{op: OP_ACC_ADD, cond: COND_NEVER,      target: STEP_IDLE};
      4'd11: w = '{op: OP_OUT,     cond: COND_OUT_BUSY,   target: STEP_OUT};
      4'd12: w = '{op: OP_NOP,     cond: COND_ALWAYS,     target: STEP_IDLE};
      default: w = '{op: OP_NOP,   cond: COND_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> src/pid_position_motor_drive.sv
// ----------------------------------------------------------------------------
// pid_position_motor_drive
// Fixed-point PID position controller driving a motor PWM and direction.
// ----------------------------------------------------------------------------
// Each input word carries an encoder count and a millisecond timestamp and
// produces exactly one result word: PWM duty, drive direction, an at-target
// flag and the saturated position error. The count is scaled to degrees by
// the Q8.8 ratio, compared with the target angle, and the elapsed time since
// the previous word updates a saturating integral and a derivative (zero when
// no time has passed). A microcoded sequencer runs one word at a time through
// a single shared multiplier and a one-bit-per-cycle divider; the divider
// sets the pace unless the elapsed time is zero, when it finishes at once. A
// word waits to enter the result register while the consumer leaves the
// previous result blocked there. The next word is accepted while a finished
// result still waits in the output register. The configuration port is always
// ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module pid_position_motor_drive
  import ppmd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COUNT_W-1:0] encoder_count,
  input  logic [TIME_W-1:0]         sample_time_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PWM_W-1:0]          pwm_duty,
  output logic [1:0]                drive_direction,
  output logic                      at_target,
  output logic signed [ERR_W-1:0]   position_error,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COEF_W-1:0]         cfg_data
);

  op_t        op;
  dp_status_t status;
  logic       in_fire;
  logic       cfg_fire;

  // Register writes are always accepted, so the port never stalls.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;

  ppmd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  ppmd_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .status          (status),
    .in_fire         (in_fire),
    .encoder_count   (encoder_count),
    .sample_time_ms  (sample_time_ms),
    .cfg_fire        (cfg_fire),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pwm_duty        (pwm_duty),
    .drive_direction (drive_direction),
    .at_target       (at_target),
    .position_error  (position_error)
  );

endmodule

>>> src/ppmd_div.sv
// ----------------------------------------------------------------------------
// ppmd_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. A zero divisor gives a zero quotient at once.
// ----------------------------------------------------------------------------
module ppmd_div
  import ppmd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] dividend,
  input  logic [TIME_W-1:0]        divisor,
  output logic                     busy,
  output logic signed [DIFF_W-1:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    dvs;
  logic [DIFF_W-1:0]    quo_sh;
  logic                 neg;
  logic [TIME_W:0]      rem_sh;
  logic                 fits;

  assign rem_sh = {rem, quo_sh[DIFF_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      if (divisor == '0) begin
        busy     <= 1'b0;
        quotient <= '0;
      end else begin
        busy   <= 1'b1;
        cnt    <= DIV_CNT_W'(DIV_STEPS + 1);
        rem    <= '0;
        dvs    <= divisor;
        neg    <= dividend[DIFF_W-1];
        quo_sh <= dividend[DIFF_W-1] ? DIFF_W'(-dividend) : dividend;
      end
    end else if (busy) begin
      if (cnt == DIV_CNT_W'(1)) begin
        // Final cycle applies the sign of the dividend.
        quotient <= neg ? -$signed(quo_sh) : $signed(quo_sh);
        busy     <= 1'b0;
      end else begin
        if (fits) begin
          rem <= TIME_W'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= rem_sh[TIME_W-1:0];
        end
        quo_sh <= {quo_sh[DIFF_W-2:0], fits};
      end
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

endmodule

>>> src/ppmd_datapath.sv
// ----------------------------------------------------------------------------
// ppmd_datapath
// Configuration registers, controller state, shared multiplier, accumulator
// and result register, all steered by the current micro-operation.
// ----------------------------------------------------------------------------
module ppmd_datapath
  import ppmd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  op_t                       op,
  output dp_status_t                status,
  input  logic                      in_fire,
  input  logic signed [COUNT_W-1:0] encoder_count,
  input  logic [TIME_W-1:0]         sample_time_ms,
  input  logic                      cfg_fire,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COEF_W-1:0]         cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PWM_W-1:0]          pwm_duty,
  output logic [1:0]                drive_direction,
  output logic                      at_target,
  output logic signed [ERR_W-1:0]   position_error
);

  logic [TGT_W-1:0]          target_position;
  logic [COEF_W-1:0]         counts_to_degrees;
  logic [COEF_W-1:0]         gain_p;
  logic [COEF_W-1:0]         gain_i;
  logic [COEF_W-1:0]         gain_d;

  logic [TIME_W-1:0]         last_time;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [SUM_W-1:0]   error_sum;

  logic signed [COUNT_W-1:0] count_q;
  logic [TIME_W-1:0]         now_q;
  logic signed [ERR_W-1:0]   err;
  logic [TIME_W-1:0]         dt;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      mul_en;

  logic signed [PROD_W-9:0]  err_full;
  logic signed [ERR_W-1:0]   err_next;
  logic signed [ACC_W-1:0]   sum_full;
  logic signed [SUM_W-1:0]   error_sum_next;
  logic signed [ACC_W-9:0]   ctrl;
  logic [ACC_W-9:0]          ctrl_mag;
  logic [PWM_W-1:0]          mag;
  logic signed [DIFF_W-1:0]  diff;
  logic                      div_start;
  logic                      div_busy;
  logic signed [DIFF_W-1:0]  div_q;
  logic                      out_free;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_position   <= '0;
      counts_to_degrees <= CTD_RESET;
      gain_p            <= '0;
      gain_i            <= '0;
      gain_d            <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_TARGET: target_position   <= cfg_data[TGT_W-1:0];
        REG_CTD:    counts_to_degrees <= cfg_data;
        REG_GAIN_P: gain_p            <= cfg_data;
        REG_GAIN_I: gain_i            <= cfg_data;
        REG_GAIN_D: gain_d            <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (op)
      OP_MUL_POS: begin
        mul_a = {{(MUL_A_W-COEF_W){1'b0}}, counts_to_degrees};
        mul_b = {{(MUL_B_W-COUNT_W){count_q[COUNT_W-1]}}, count_q};
      end
      OP_MUL_EDT: begin
        mul_a = {1'b0, dt};
        mul_b = {err[ERR_W-1], err};
      end
      OP_MUL_I: begin
        mul_a = {error_sum[SUM_W-1], error_sum};
        mul_b = {{(MUL_B_W-COEF_W){1'b0}}, gain_i};
      end
      OP_MUL_P: begin
        mul_a = {{(MUL_A_W-COEF_W){1'b0}}, gain_p};
        mul_b = {err[ERR_W-1], err};
      end
      OP_MUL_D: begin
        mul_a = {{(MUL_A_W-COEF_W){1'b0}}, gain_d};
        mul_b = div_q;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Position is the product floored by 256; the error saturates to 21 bits.
  always_comb begin
    err_full = $signed(prod[PROD_W-1:8])
             - (PROD_W-8)'($signed({1'b0, target_position}));
    if (err_full > (PROD_W-8)'(ERR_MAX)) begin
      err_next = ERR_MAX;
    end else if (err_full < (PROD_W-8)'(ERR_MIN)) begin
      err_next = ERR_MIN;
    end else begin
      err_next = err_full[ERR_W-1:0];
    end
  end

  always_comb begin
    sum_full = {{(ACC_W-SUM_W){error_sum[SUM_W-1]}}, error_sum} + {prod[PROD_W-1], prod};
    if (sum_full > ACC_W'(SUM_MAX)) begin
      error_sum_next = SUM_MAX;
    end else if (sum_full < ACC_W'(SUM_MIN)) begin
      error_sum_next = SUM_MIN;
    end else begin
      error_sum_next = sum_full[SUM_W-1:0];
    end
  end

  // Controller output floored by 256, then magnitude clamped to the PWM range.
  always_comb begin
    ctrl     = acc[ACC_W-1:8];
    ctrl_mag = ctrl[ACC_W-9] ? (ACC_W-8)'(-ctrl) : ctrl;
    if (ctrl_mag > (ACC_W-8)'(PWM_MAX)) begin
      mag = PWM_MAX;
    end else begin
      mag = ctrl_mag[PWM_W-1:0];
    end
  end

  assign diff      = $signed({err[ERR_W-1], err}) - $signed({last_error[ERR_W-1], last_error});
  assign div_start = (op == OP_MUL_EDT);

  ppmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= '0;
      last_error <= '0;
      error_sum  <= '0;
    end else begin
      case (op)
        OP_ERR: last_time <= now_q;
        OP_SUM: begin
          error_sum  <= error_sum_next;
          last_error <= err;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      count_q <= encoder_count;
      now_q   <= sample_time_ms;
    end
    if (mul_en) begin
      prod <= mul_p;
    end
    case (op)
      OP_ERR: begin
        err <= err_next;
        dt  <= now_q - last_time;
      end
      OP_MUL_P:   acc <= {prod[PROD_W-1], prod};
      OP_ACC_ADD: acc <= acc + {prod[PROD_W-1], prod};
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT && out_free) begin
      position_error <= err;
      if (err == '0) begin
        pwm_duty        <= '0;
        drive_direction <= DIR_STOP;
        at_target       <= 1'b1;
      end else begin
        pwm_duty        <= mag;
        drive_direction <= err[ERR_W-1] ? DIR_CW : DIR_CCW;
        at_target       <= 1'b0;
      end
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_busy = !out_free;

endmodule

>>> src/ppmd_seq.sv
// ----------------------------------------------------------------------------
// ppmd_seq
// Microcode sequencer: step counter, program lookup and conditional jumps.
// ----------------------------------------------------------------------------
module ppmd_seq
  import ppmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output op_t        op
);

  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   jump;

  assign uw       = ucode_rom(step);
  assign op       = uw.op;
  assign in_ready = (uw.cond == COND_WAIT_INPUT);

  always_comb begin
    case (uw.cond)
      COND_NEVER:      jump = 1'b0;
      COND_WAIT_INPUT: jump = !in_valid;
      COND_DIV_BUSY:   jump = status.div_busy;
      COND_OUT_BUSY:   jump = status.out_busy;
      COND_ALWAYS:     jump = 1'b1;
      default:         jump = 1'b1;
    endcase
  end

  always_comb begin
    step_next = jump ? uw.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> src/ppmd_checker.sv
// ----------------------------------------------------------------------------
// ppmd_checker
// Port-level checks of the PID position motor drive, bound to the top level.
// ----------------------------------------------------------------------------
module ppmd_checker
  import ppmd_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [PWM_W-1:0]        pwm_duty,
  input logic [1:0]              drive_direction,
  input logic                    at_target,
  input logic signed [ERR_W-1:0] position_error
);

  // No result may appear on the cycle right after reset.
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pwm_duty) && $stable(position_error))
    else $error("stalled result changed");

  a_target_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (at_target == (position_error == '0)))
    else $error("at_target disagrees with error");

  a_stop_at_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && at_target |-> pwm_duty == '0 && drive_direction == DIR_STOP)
    else $error("motor not stopped at target");

  a_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid && !at_target |->
      drive_direction == (position_error[ERR_W-1] ? DIR_CW : DIR_CCW))
    else $error("direction disagrees with error sign");

endmodule

bind pid_position_motor_drive ppmd_checker u_ppmd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .pwm_duty        (pwm_duty),
  .drive_direction (drive_direction),
  .at_target       (at_target),
  .position_error  (position_error)
);
